### hdl/mhae_pkg.sv
// Package holding the request and result types and the constants of the address field encoder.
`default_nettype none
package mhae_pkg;

  localparam logic [7:0] LEN_NONE  = 8'd0;
  localparam logic [7:0] LEN_SHORT = 8'd2;
  localparam logic [7:0] LEN_EXT   = 8'd8;

  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_SHORT = 2'd2;
  localparam logic [1:0] MODE_EXT   = 2'd3;

  localparam logic [4:0] HDR_START  = 5'd3;
  localparam logic [7:0] INTRA_BIT  = 8'h40;
  localparam logic [7:0] DMODE_MASK = 8'h0C;
  localparam logic [7:0] SMODE_MASK = 8'hC0;

  typedef struct packed {
    logic [7:0]  dest_len;
    logic [15:0] dest_pan;
    logic [15:0] dest_short;
    logic [63:0] dest_ext;
    logic [7:0]  src_len;
    logic [15:0] src_pan;
    logic [15:0] src_short;
    logic [63:0] src_ext;
    logic [7:0]  fc_low_in;
    logic [7:0]  fc_high_in;
  } in_req_t;

  typedef struct packed {
    logic [7:0] hdr_byte;
    logic [4:0] byte_offset;
    logic       byte_valid;
    logic [7:0] fc_low_out;
    logic [7:0] fc_high_out;
    logic [4:0] header_end;
    logic       error;
    logic       last;
  } out_req_t;

  function automatic logic len_ok(input logic [7:0] len);
    return (len == LEN_NONE) || (len == LEN_SHORT) || (len == LEN_EXT);
  endfunction

  function automatic logic [1:0] mode_of(input logic [7:0] len);
    logic [1:0] m;
    m = MODE_NONE;
    if (len == LEN_SHORT) m = MODE_SHORT;
    else if (len == LEN_EXT) m = MODE_EXT;
    return m;
  endfunction

endpackage
`default_nettype wire

### hdl/mhae_fmt.sv
// Result formatter: builds the result for one byte index of a held request.
`default_nettype none
module mhae_fmt (
  input  mhae_pkg::in_req_t  item,
  input  logic [4:0]         idx,
  output mhae_pkg::out_req_t res
);
  import mhae_pkg::*;

  logic       bad;
  logic       d_pres;
  logic       s_pres;
  logic       intra;
  logic [4:0] d_alen;
  logic [4:0] s_alen;
  logic [4:0] d_end;
  logic [4:0] s_pan_n;
  logic [4:0] s_start;
  logic [4:0] n_bytes;
  logic [4:0] off;
  logic [7:0] sel_byte;
  logic [7:0] fcl;
  logic [7:0] fch;

  always_comb begin
    bad     = !len_ok(item.dest_len) || !len_ok(item.src_len);
    d_pres  = (item.dest_len != LEN_NONE);
    s_pres  = (item.src_len != LEN_NONE);
    intra   = d_pres && s_pres && (item.dest_pan == item.src_pan);
    d_alen  = (item.dest_len == LEN_EXT) ? 5'd8 : 5'd2;
    s_alen  = (item.src_len == LEN_EXT) ? 5'd8 : 5'd2;
    d_end   = d_pres ? (5'd2 + d_alen) : 5'd0;
    s_pan_n = (s_pres && !intra) ? 5'd2 : 5'd0;
    s_start = d_end + s_pan_n;
    n_bytes = s_start + (s_pres ? s_alen : 5'd0);

    off      = 5'd0;
    sel_byte = 8'd0;
    priority if (idx < d_end) begin
      if (idx < 5'd2) begin
        sel_byte = idx[0] ? item.dest_pan[15:8] : item.dest_pan[7:0];
      end else begin
        off = idx - 5'd2;
        if (item.dest_len == LEN_EXT) begin
          sel_byte = item.dest_ext[{off[2:0], 3'b000} +: 8];
        end else begin
          sel_byte = off[0] ? item.dest_short[15:8] : item.dest_short[7:0];
        end
      end
    end else if (idx < s_start) begin
      off      = idx - d_end;
      sel_byte = off[0] ? item.src_pan[15:8] : item.src_pan[7:0];
    end else begin
      off = idx - s_start;
      if (item.src_len == LEN_EXT) begin
        sel_byte = item.src_ext[{off[2:0], 3'b000} +: 8];
      end else begin
        sel_byte = off[0] ? item.src_short[15:8] : item.src_short[7:0];
      end
    end

    fcl = intra ? (item.fc_low_in | INTRA_BIT) : (item.fc_low_in & ~INTRA_BIT);
    fch = (item.fc_high_in & ~(DMODE_MASK | SMODE_MASK))
        | {mode_of(item.src_len), 2'b00, mode_of(item.dest_len), 2'b00};

    if (bad) begin
      res.hdr_byte    = 8'd0;
      res.byte_offset = HDR_START;
      res.byte_valid  = 1'b0;
      res.fc_low_out  = item.fc_low_in;
      res.fc_high_out = item.fc_high_in;
      res.header_end  = HDR_START;
      res.error       = 1'b1;
      res.last        = 1'b1;
    end else if (n_bytes == 5'd0) begin
      res.hdr_byte    = 8'd0;
      res.byte_offset = HDR_START;
      res.byte_valid  = 1'b0;
      res.fc_low_out  = fcl;
      res.fc_high_out = fch;
      res.header_end  = HDR_START;
      res.error       = 1'b0;
      res.last        = 1'b1;
    end else begin
      res.hdr_byte    = sel_byte;
      res.byte_offset = HDR_START + idx;
      res.byte_valid  = 1'b1;
      res.fc_low_out  = fcl;
      res.fc_high_out = fch;
      res.header_end  = HDR_START + n_bytes;
      res.error       = 1'b0;
      res.last        = (idx + 5'd1 == n_bytes);
    end
  end

endmodule
`default_nettype wire

### hdl/mac_header_address_encoder.sv
// Top level of the address field encoder: request register, byte walker and result register.
// A request enters the request register, then each of its results the result register.
// One result per cycle unless the output stalls; n address bytes of a request give n results
// (one if none or invalid), each from the single byte selection path on the held request.
// The next request is taken in the cycle its predecessor's last result is registered.
// Synchronous active-low reset empties the request and result registers.
`default_nettype none
module mac_header_address_encoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mhae_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_ready,
  output mhae_pkg::out_req_t out_req
);
  import mhae_pkg::*;

  in_req_t    item_r;
  logic       item_vld_r;
  logic       item_vld_nxt;
  logic [4:0] idx_r;
  logic [4:0] idx_nxt;
  out_req_t   out_r;
  logic       out_vld_r;
  logic       out_vld_nxt;
  out_req_t   res;
  logic       advance;
  logic       emit;
  logic       done;
  logic       take;

  mhae_fmt u_fmt (
    .item (item_r),
    .idx  (idx_r),
    .res  (res)
  );

  always_comb begin
    advance = !out_vld_r || out_ready;
    emit    = item_vld_r && advance;
    done    = emit && res.last;
    take    = in_valid && in_ready;

    item_vld_nxt = item_vld_r;
    if (take) item_vld_nxt = 1'b1;
    else if (done) item_vld_nxt = 1'b0;

    idx_nxt = idx_r;
    if (done) idx_nxt = 5'd0;
    else if (emit) idx_nxt = idx_r + 5'd1;

    out_vld_nxt = out_vld_r;
    if (emit) out_vld_nxt = 1'b1;
    else if (out_ready) out_vld_nxt = 1'b0;
  end

  assign in_ready  = !item_vld_r || done;
  assign out_valid = out_vld_r;
  assign out_req   = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      idx_r      <= 5'd0;
      out_vld_r  <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
      idx_r      <= idx_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) item_r <= in_req;
    if (emit) out_r <= res;
  end

endmodule
`default_nettype wire

### hdl/mhae_checker.sv
// Port checker for the address field encoder and its bind to the top level.
`default_nettype none
module mhae_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input mhae_pkg::out_req_t out_req
);
  import mhae_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_req))
    else $error("Result changed while stalled.");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_req.error |-> out_req.last && !out_req.byte_valid)
    else $error("Error result is not a lone final result.");

  a_novalid_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_req.byte_valid |-> out_req.last && out_req.header_end == HDR_START)
    else $error("Empty result is not final.");

  a_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_req.byte_valid |-> out_req.byte_offset < out_req.header_end)
    else $error("Byte offset beyond header end.");

  a_next_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_req.last ##1 out_valid |->
      out_req.byte_offset == $past(out_req.byte_offset) + 5'd1)
    else $error("Byte offsets of one request are not consecutive.");

endmodule

bind mac_header_address_encoder mhae_checker u_mhae_checker (.*);
`default_nettype wire
